// ===== src/tdfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tdfsm_pkg
// Shared types, codes and constants of the table-driven state machine engine.
// ----------------------------------------------------------------------------
package tdfsm_pkg;

  localparam int NUM_STATES_DEF      = 16;
  localparam int NUM_TRANSITIONS_DEF = 32;
  localparam int NUM_CONDITIONS_DEF  = 16;
  localparam int ACTION_BITS_DEF     = 8;

  // item modes
  localparam logic [2:0] MODE_LOAD_STATE = 3'd0;
  localparam logic [2:0] MODE_LOAD_TRANS = 3'd1;
  localparam logic [2:0] MODE_START      = 3'd2;
  localparam logic [2:0] MODE_TICK       = 3'd3;
  localparam logic [2:0] MODE_EVENT      = 3'd4;
  localparam logic [2:0] MODE_SET_COND   = 3'd5;

  // trigger kinds
  localparam logic [1:0] TRIG_EVENT   = 2'd0;
  localparam logic [1:0] TRIG_COND    = 2'd1;
  localparam logic [1:0] TRIG_TIMEOUT = 2'd2;

  // action kinds
  localparam logic [1:0] ACT_EXIT   = 2'd0;
  localparam logic [1:0] ACT_ENTER  = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  // error codes
  localparam logic [1:0] ERR_OK          = 2'd0;
  localparam logic [1:0] ERR_NOT_STARTED = 2'd1;
  localparam logic [1:0] ERR_NOT_CONFIG  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INITIAL_STATE    = 2'd0;
  localparam logic [1:0] REG_STATE_COUNT      = 2'd1;
  localparam logic [1:0] REG_TRANSITION_COUNT = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  entry_index;
    logic [3:0]  from_state;
    logic [3:0]  to_state;
    logic [1:0]  trigger_kind;
    logic [31:0] trigger_value;
    logic [7:0]  enter_code;
    logic [7:0]  update_code;
    logic [7:0]  exit_code;
    logic        flag;
    logic [15:0] elapsed_ticks;
    logic [7:0]  signal_id;
  } in_item_t;

  typedef struct packed {
    logic        action_valid;
    logic [7:0]  action_code;
    logic [1:0]  action_kind;
    logic [3:0]  current_state_out;
    logic [31:0] time_in_state_out;
    logic        done_res;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PREP,
    CS_SCAN,
    CS_FIRE_EXIT,
    CS_FIRE_ENTER,
    CS_UPDATE,
    CS_EMIT
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;      // latch input word and apply immediate effects
    logic scan_start;  // clear scan index
    logic scan_step;   // advance scan index
    logic fire;        // move to matched target
    logic push_exit;
    logic push_enter;
    logic push_update;
    logic pop;         // result word taken
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scan_active; // item needs a table scan
    logic       scan_end;    // index reached count
    logic       hit;         // current entry matches
    logic       is_tick;
    logic       is_start;    // start word that entered the initial state
    logic       queue_empty;
    logic       queue_one;   // exactly one word left
  } dp_sts_t;

endpackage

// ===== src/tdfsm_datapath.sv =====
// ----------------------------------------------------------------------------
// tdfsm_datapath
// Tables, machine state, scan index and result queue of the engine.
// ----------------------------------------------------------------------------
module tdfsm_datapath #(
  parameter int NUM_STATES      = tdfsm_pkg::NUM_STATES_DEF,
  parameter int NUM_TRANSITIONS = tdfsm_pkg::NUM_TRANSITIONS_DEF,
  parameter int NUM_CONDITIONS  = tdfsm_pkg::NUM_CONDITIONS_DEF,
  parameter int ACTION_BITS     = tdfsm_pkg::ACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tdfsm_pkg::in_item_t in_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  tdfsm_pkg::dp_cmd_t  cmd,
  output tdfsm_pkg::dp_sts_t  sts,
  output tdfsm_pkg::out_item_t out_word
);

  localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int TW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
  localparam int CW = (NUM_CONDITIONS > 1) ? $clog2(NUM_CONDITIONS) : 1;
  localparam int SCW = $clog2(NUM_STATES + 1);
  localparam int TCW = $clog2(NUM_TRANSITIONS + 1);
  localparam int STW = 3 * ACTION_BITS + 1;

  // state table entry: enter, update, exit, terminal
  logic [STW-1:0] st_mem [NUM_STATES];
  // transition table entry: src, dst, kind, value
  logic [41:0]    tr_mem [NUM_TRANSITIONS];
  logic [41:0]    tr_rd;

  logic [NUM_CONDITIONS-1:0] cond;
  logic [3:0]  cur;
  logic [31:0] tcount;
  logic        running;
  logic [3:0]  init_state;
  logic [4:0]  state_count;
  logic [5:0]  trans_count;
  logic [1:0]  err;
  logic [2:0]  mode;
  logic [7:0]  sig;
  logic [TCW-1:0] scan_idx;
  logic [3:0]  hit_dst;

  // result queue of at most three action words
  logic [7:0]  q_code [3];
  logic [1:0]  q_kind [3];
  logic [1:0]  q_cnt;
  logic [1:0]  q_rd;

  logic [SCW-1:0] st_used;
  logic [TCW-1:0] tr_used;
  logic        cur_in_use;
  logic [STW-1:0] cur_entry;
  logic [7:0]  enter_c, update_c, exit_c;
  logic        term;
  logic        tick_go, event_go;
  logic [3:0]  t_src, t_dst;
  logic [1:0]  t_kind;
  logic [31:0] t_val;
  logic [32:0] tsum;

  // saturated counts
  always_comb begin
    if ({27'd0, state_count} > NUM_STATES) st_used = SCW'(NUM_STATES);
    else st_used = SCW'(state_count);
    if ({26'd0, trans_count} > NUM_TRANSITIONS) tr_used = TCW'(NUM_TRANSITIONS);
    else tr_used = TCW'(trans_count);
  end

  // current state entry
  always_comb begin
    cur_in_use = ({28'd0, cur} < 32'(st_used));
    cur_entry  = st_mem[SW'(cur)];
    enter_c    = 8'(cur_entry[STW-1 -: ACTION_BITS]);
    update_c   = 8'(cur_entry[STW-1-ACTION_BITS -: ACTION_BITS]);
    exit_c     = 8'(cur_entry[ACTION_BITS:1]);
    term       = cur_entry[0];
  end

  // transition entry under scan
  always_comb begin
    t_src  = tr_rd[41:38];
    t_dst  = tr_rd[37:34];
    t_kind = tr_rd[33:32];
    t_val  = tr_rd[31:0];
    tick_go = 1'b0;
    if (t_kind == tdfsm_pkg::TRIG_COND)
      tick_go = (t_val < 32'(NUM_CONDITIONS)) && cond[CW'(t_val)];
    else if (t_kind == tdfsm_pkg::TRIG_TIMEOUT)
      tick_go = (t_val != 32'd0) && (tcount >= t_val);
    event_go = (t_kind == tdfsm_pkg::TRIG_EVENT) && (t_val == {24'd0, sig});
  end

  assign tsum = {1'b0, tcount} + {17'd0, in_word.elapsed_ticks};

  always_comb begin
    sts.is_tick     = (mode == tdfsm_pkg::MODE_TICK);
    sts.is_start    = (mode == tdfsm_pkg::MODE_START) && (err == tdfsm_pkg::ERR_OK);
    sts.scan_active = running && (err == tdfsm_pkg::ERR_OK) &&
                      (mode == tdfsm_pkg::MODE_TICK || mode == tdfsm_pkg::MODE_EVENT);
    sts.scan_end    = (scan_idx >= tr_used);
    sts.hit         = (t_src == cur) &&
                      ((mode == tdfsm_pkg::MODE_TICK) ? tick_go : event_go);
    sts.queue_empty = (q_cnt == q_rd);
    sts.queue_one   = (q_cnt == q_rd + 2'd1);
  end

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.accept && in_word.mode == tdfsm_pkg::MODE_LOAD_STATE &&
        {27'd0, in_word.entry_index} < NUM_STATES)
      st_mem[SW'(in_word.entry_index)] <= {ACTION_BITS'(in_word.enter_code),
        ACTION_BITS'(in_word.update_code), ACTION_BITS'(in_word.exit_code), in_word.flag};
    if (cmd.accept && in_word.mode == tdfsm_pkg::MODE_LOAD_TRANS &&
        {27'd0, in_word.entry_index} < NUM_TRANSITIONS)
      tr_mem[TW'(in_word.entry_index)] <= {in_word.from_state, in_word.to_state,
        in_word.trigger_kind, in_word.trigger_value};
    tr_rd <= tr_mem[TW'(cmd.scan_start ? '0 : (cmd.scan_step ? scan_idx + 1'b1 : scan_idx))];
  end

  // machine state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cond <= '0; cur <= '0; tcount <= '0; running <= 1'b0;
      init_state <= '0; state_count <= '0; trans_count <= '0;
      err <= tdfsm_pkg::ERR_OK; mode <= '0; sig <= '0; scan_idx <= '0;
      q_cnt <= '0; q_rd <= '0; hit_dst <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tdfsm_pkg::REG_INITIAL_STATE: begin
            init_state <= cfg_data[3:0]; running <= 1'b0;
          end
          tdfsm_pkg::REG_STATE_COUNT: begin
            state_count <= cfg_data[4:0]; running <= 1'b0;
          end
          tdfsm_pkg::REG_TRANSITION_COUNT: begin
            trans_count <= cfg_data[5:0]; running <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.accept) begin
        mode  <= in_word.mode;
        sig   <= in_word.signal_id;
        err   <= tdfsm_pkg::ERR_OK;
        q_cnt <= '0;
        q_rd  <= '0;
        case (in_word.mode)
          tdfsm_pkg::MODE_START: begin
            if (state_count == 5'd0) err <= tdfsm_pkg::ERR_NOT_CONFIG;
            else begin
              cur <= init_state; tcount <= '0; running <= 1'b1;
            end
          end
          tdfsm_pkg::MODE_TICK: begin
            if (!running) err <= tdfsm_pkg::ERR_NOT_STARTED;
            else tcount <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
          end
          tdfsm_pkg::MODE_EVENT: begin
            if (!running) err <= tdfsm_pkg::ERR_NOT_STARTED;
          end
          tdfsm_pkg::MODE_SET_COND: begin
            if ({24'd0, in_word.signal_id} < NUM_CONDITIONS)
              cond[CW'(in_word.signal_id)] <= in_word.flag;
          end
          default: ;
        endcase
      end
      if (cmd.scan_start) scan_idx <= '0;
      else if (cmd.scan_step) scan_idx <= scan_idx + 1'b1;
      if (sts.hit) hit_dst <= t_dst;
      if (cmd.fire) begin
        cur <= hit_dst; tcount <= '0;
      end
      if (cmd.push_exit || cmd.push_enter || cmd.push_update) begin
        if (cur_in_use && q_cnt != 2'd3) begin
          if (cmd.push_exit && exit_c != 8'd0) begin
            q_code[q_cnt] <= exit_c; q_kind[q_cnt] <= tdfsm_pkg::ACT_EXIT;
            q_cnt <= q_cnt + 2'd1;
          end
          if (cmd.push_enter && enter_c != 8'd0) begin
            q_code[q_cnt] <= enter_c; q_kind[q_cnt] <= tdfsm_pkg::ACT_ENTER;
            q_cnt <= q_cnt + 2'd1;
          end
          if (cmd.push_update && update_c != 8'd0) begin
            q_code[q_cnt] <= update_c; q_kind[q_cnt] <= tdfsm_pkg::ACT_UPDATE;
            q_cnt <= q_cnt + 2'd1;
          end
        end
      end
      if (cmd.pop && !sts.queue_empty) q_rd <= q_rd + 2'd1;
    end
  end

  // result word
  always_comb begin
    out_word.action_valid      = !sts.queue_empty;
    out_word.action_code       = sts.queue_empty ? 8'd0 : q_code[q_rd];
    out_word.action_kind       = sts.queue_empty ? tdfsm_pkg::ACT_EXIT : q_kind[q_rd];
    out_word.current_state_out = cur;
    out_word.time_in_state_out = tcount;
    out_word.done_res          = running && cur_in_use && term;
    out_word.error_code        = err;
    out_word.last              = sts.queue_empty || sts.queue_one;
  end

endmodule

// ===== src/tdfsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdfsm_ctrl
// Sequencer: accepts a word, scans transitions, queues actions, emits results.
// ----------------------------------------------------------------------------
module tdfsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               busy,
  input  tdfsm_pkg::dp_sts_t sts,
  output tdfsm_pkg::dp_cmd_t cmd
);

  tdfsm_pkg::ctl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= tdfsm_pkg::CS_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    busy       = (state != tdfsm_pkg::CS_IDLE);
    case (state)
      tdfsm_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = tdfsm_pkg::CS_PREP;
        end
      end
      tdfsm_pkg::CS_PREP: begin
        // start pushes its enter action here
        cmd.scan_start = 1'b1;
        cmd.push_enter = sts.is_start;
        state_next = sts.scan_active ? tdfsm_pkg::CS_SCAN : tdfsm_pkg::CS_EMIT;
      end
      tdfsm_pkg::CS_SCAN: begin
        if (sts.scan_end) begin
          state_next = sts.is_tick ? tdfsm_pkg::CS_UPDATE : tdfsm_pkg::CS_EMIT;
        end else if (sts.hit) begin
          state_next = tdfsm_pkg::CS_FIRE_EXIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      tdfsm_pkg::CS_FIRE_EXIT: begin
        cmd.push_exit = 1'b1;
        cmd.fire      = 1'b1;
        state_next    = tdfsm_pkg::CS_FIRE_ENTER;
      end
      tdfsm_pkg::CS_FIRE_ENTER: begin
        cmd.push_enter = 1'b1;
        state_next = sts.is_tick ? tdfsm_pkg::CS_UPDATE : tdfsm_pkg::CS_EMIT;
      end
      tdfsm_pkg::CS_UPDATE: begin
        cmd.push_update = 1'b1;
        state_next = tdfsm_pkg::CS_EMIT;
      end
      tdfsm_pkg::CS_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.pop = 1'b1;
          if (sts.queue_empty || sts.queue_one) state_next = tdfsm_pkg::CS_IDLE;
        end
      end
      default: state_next = tdfsm_pkg::CS_IDLE;
    endcase
  end

endmodule

// ===== src/table_driven_fsm_engine.sv =====
// ----------------------------------------------------------------------------
// table_driven_fsm_engine
// Programmable table-driven state machine with loadable state and transition
// tables, condition flags and a saturating time-in-state counter.
// ----------------------------------------------------------------------------
// An item is accepted and passes a set-up state. For tick and event words the
// sequencer then examines transition entries up to the first match and queues
// the actions. Result words (one to three) are delivered as the output takes
// them. The scan is bounded by the single read port of the transition table,
// which the sequencer walks one entry a cycle. A new word is taken once the last
// result word of the previous one has left.
module table_driven_fsm_engine #(
  parameter int NUM_STATES      = tdfsm_pkg::NUM_STATES_DEF,
  parameter int NUM_TRANSITIONS = tdfsm_pkg::NUM_TRANSITIONS_DEF,
  parameter int NUM_CONDITIONS  = tdfsm_pkg::NUM_CONDITIONS_DEF,
  parameter int ACTION_BITS     = tdfsm_pkg::ACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tdfsm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tdfsm_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  tdfsm_pkg::dp_cmd_t cmd;
  tdfsm_pkg::dp_sts_t sts;
  logic busy;

  assign cfg_ready = 1'b1;

  tdfsm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .busy, .sts, .cmd
  );

  tdfsm_datapath #(
    .NUM_STATES(NUM_STATES), .NUM_TRANSITIONS(NUM_TRANSITIONS),
    .NUM_CONDITIONS(NUM_CONDITIONS), .ACTION_BITS(ACTION_BITS)
  ) u_dp (
    .clk, .rst, .in_word(in_data), .cfg_we(cfg_valid & cfg_ready),
    .cfg_index, .cfg_data, .cmd, .sts, .out_word(out_data)
  );

  // input and output never handshake in the same cycle
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output both open");

  // an accepted word always leads through set-up
  a_prep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> busy && !out_valid)
    else $error("accept not followed by processing");

  // a delivered last word frees the input side
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> in_ready)
    else $error("input not reopened after last word");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the table-driven state machine engine. Loads the
// state and transition tables, walks the engine through several register
// settings with directed and random words under random idling on both sides,
// and compares every result word against a cycle-free behavioural predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam int         CYCLE_CAP  = 600000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tdfsm_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tdfsm_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  bit                   calm = 1'b0;
  int                   cycles = 0;

  // behavioural predictor and store of pending result words
  class engine_scoreboard;
    logic [7:0]  enter_act[16];
    logic [7:0]  update_act[16];
    logic [7:0]  exit_act[16];
    bit          terminal[16];
    logic [3:0]  tr_src[32];
    logic [3:0]  tr_dst[32];
    logic [1:0]  tr_kind[32];
    logic [31:0] tr_val[32];
    bit          cond[16];
    logic [3:0]  cur_state;
    logic [31:0] dwell;
    bit          running;
    logic [3:0]  init_state;
    logic [4:0]  state_cnt;
    logic [5:0]  trans_cnt;
    logic [7:0]  act_code[$];
    logic [1:0]  act_kind[$];
    tdfsm_pkg::out_item_t pending_words[$];
    int          errors;

    function new();
      foreach (cond[i]) cond[i] = 1'b0;
      cur_state = '0;
      dwell = '0;
      running = 1'b0;
      init_state = '0;
      state_cnt = '0;
      trans_cnt = '0;
      errors = 0;
    endfunction

    function int states_in_use();
      return (state_cnt > 16) ? 16 : int'(state_cnt);
    endfunction

    function int trans_in_use();
      return (trans_cnt > 32) ? 32 : int'(trans_cnt);
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function void report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        tdfsm_pkg::REG_INITIAL_STATE:    init_state = value[3:0];
        tdfsm_pkg::REG_STATE_COUNT:      state_cnt = value[4:0];
        tdfsm_pkg::REG_TRANSITION_COUNT: trans_cnt = value[5:0];
        default:                         return;
      endcase
      running = 1'b0;
    endfunction

    function void add_action(logic [1:0] kind, logic [7:0] code);
      if (code == '0 || act_code.size() >= 3) return;
      act_code = {act_code, code};
      act_kind = {act_kind, kind};
    endfunction

    function void move_to(logic [3:0] dst);
      if (cur_state < states_in_use())
        add_action(tdfsm_pkg::ACT_EXIT, exit_act[cur_state]);
      cur_state = dst;
      dwell = '0;
      if (cur_state < states_in_use())
        add_action(tdfsm_pkg::ACT_ENTER, enter_act[cur_state]);
    endfunction

    // work out the result words of one accepted input word
    function void note_word(tdfsm_pkg::in_item_t w);
      logic [1:0]  err;
      logic [32:0] sum;
      bit          go;
      tdfsm_pkg::out_item_t r;
      int          n;
      err = tdfsm_pkg::ERR_OK;
      act_code.delete();
      act_kind.delete();
      case (w.mode)
        tdfsm_pkg::MODE_LOAD_STATE: if (w.entry_index < 16) begin
          enter_act[w.entry_index[3:0]] = w.enter_code;
          update_act[w.entry_index[3:0]] = w.update_code;
          exit_act[w.entry_index[3:0]] = w.exit_code;
          terminal[w.entry_index[3:0]] = w.flag;
        end
        tdfsm_pkg::MODE_LOAD_TRANS: begin
          tr_src[w.entry_index] = w.from_state;
          tr_dst[w.entry_index] = w.to_state;
          tr_kind[w.entry_index] = w.trigger_kind;
          tr_val[w.entry_index] = w.trigger_value;
        end
        tdfsm_pkg::MODE_START: begin
          if (state_cnt == '0) begin
            err = tdfsm_pkg::ERR_NOT_CONFIG;
          end else begin
            cur_state = init_state;
            dwell = '0;
            running = 1'b1;
            if (cur_state < states_in_use())
              add_action(tdfsm_pkg::ACT_ENTER, enter_act[cur_state]);
          end
        end
        tdfsm_pkg::MODE_TICK: begin
          if (!running) begin
            err = tdfsm_pkg::ERR_NOT_STARTED;
          end else begin
            sum = {1'b0, dwell} + {17'b0, w.elapsed_ticks};
            dwell = sum[32] ? '1 : sum[31:0];
            for (int i = 0; i < trans_in_use(); i++) begin
              go = 1'b0;
              if (tr_src[i] != cur_state) continue;
              if (tr_kind[i] == tdfsm_pkg::TRIG_COND)
                go = (tr_val[i] < 16) && cond[tr_val[i][3:0]];
              else if (tr_kind[i] == tdfsm_pkg::TRIG_TIMEOUT)
                go = (tr_val[i] != 0) && (dwell >= tr_val[i]);
              if (go) begin
                move_to(tr_dst[i]);
                break;
              end
            end
            if (cur_state < states_in_use())
              add_action(tdfsm_pkg::ACT_UPDATE, update_act[cur_state]);
          end
        end
        tdfsm_pkg::MODE_EVENT: begin
          if (!running) begin
            err = tdfsm_pkg::ERR_NOT_STARTED;
          end else begin
            for (int i = 0; i < trans_in_use(); i++) begin
              if (tr_src[i] == cur_state && tr_kind[i] == tdfsm_pkg::TRIG_EVENT &&
                  tr_val[i] == {24'b0, w.signal_id}) begin
                move_to(tr_dst[i]);
                break;
              end
            end
          end
        end
        tdfsm_pkg::MODE_SET_COND: if (w.signal_id < 16) cond[w.signal_id[3:0]] = w.flag;
        default: ;
      endcase
      n = (act_code.size() == 0) ? 1 : act_code.size();
      for (int k = 0; k < n; k++) begin
        r = '0;
        if (act_code.size() != 0) begin
          r.action_valid = 1'b1;
          r.action_code = act_code[k];
          r.action_kind = act_kind[k];
        end
        r.current_state_out = cur_state;
        r.time_in_state_out = dwell;
        r.done_res = running && (cur_state < states_in_use()) && terminal[cur_state];
        r.error_code = err;
        r.last = (k == n - 1);
        pending_words = {pending_words, r};
      end
    endfunction

    function void check_word(tdfsm_pkg::out_item_t got);
      tdfsm_pkg::out_item_t exp_w;
      if (pending_words.size() == 0) begin
        report($sformatf("result word with nothing pending: %h", got));
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.action_valid !== exp_w.action_valid)
        report($sformatf("action_valid %0b, want %0b", got.action_valid, exp_w.action_valid));
      if (got.action_code !== exp_w.action_code)
        report($sformatf("action_code %0d, want %0d", got.action_code, exp_w.action_code));
      if (got.action_kind !== exp_w.action_kind)
        report($sformatf("action_kind %0d, want %0d", got.action_kind, exp_w.action_kind));
      if (got.current_state_out !== exp_w.current_state_out)
        report($sformatf("current_state_out %0d, want %0d",
                         got.current_state_out, exp_w.current_state_out));
      if (got.time_in_state_out !== exp_w.time_in_state_out)
        report($sformatf("time_in_state_out %0d, want %0d",
                         got.time_in_state_out, exp_w.time_in_state_out));
      if (got.done_res !== exp_w.done_res)
        report($sformatf("done_res %0b, want %0b", got.done_res, exp_w.done_res));
      if (got.error_code !== exp_w.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, exp_w.error_code));
      if (got.last !== exp_w.last)
        report($sformatf("last %0b, want %0b", got.last, exp_w.last));
    endfunction
  endclass

  engine_scoreboard sb = new();

  table_driven_fsm_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check taken words, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(out_data);
    out_ready <= calm || ($urandom_range(99) >= 35);
  end

  function automatic int gap_len();
    if (calm || $urandom_range(99) >= 35) return 0;
    return $urandom_range(1, 4);
  endfunction

  // valid stays high across back-to-back words, dropped only for a gap or while settling
  task automatic send_word(input tdfsm_pkg::in_item_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  // drain the engine before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_regs(input logic [3:0] init_v, input logic [4:0] sc,
                            input logic [5:0] tc, input bit spare);
    logic [31:0] vals[4];
    logic [1:0]  idxs[4];
    int          n;
    vals[0] = {$urandom} & 32'hFFFF_FFF0 | init_v; idxs[0] = tdfsm_pkg::REG_INITIAL_STATE;
    vals[1] = {$urandom} & 32'hFFFF_FFE0 | sc;     idxs[1] = tdfsm_pkg::REG_STATE_COUNT;
    vals[2] = {$urandom} & 32'hFFFF_FFC0 | tc;     idxs[2] = tdfsm_pkg::REG_TRANSITION_COUNT;
    vals[3] = $urandom;                            idxs[3] = REG_SPARE;
    n = spare ? 4 : 3;
    cfg_valid <= 1'b1;
    for (int i = 0; i < n; i++) begin
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3:0] pick_state();
    return ($urandom_range(99) < 75) ? 4'($urandom_range(0, 5)) : 4'($urandom);
  endfunction

  function automatic tdfsm_pkg::in_item_t state_load(logic [4:0] idx);
    tdfsm_pkg::in_item_t w;
    w = tdfsm_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    w.mode = tdfsm_pkg::MODE_LOAD_STATE;
    w.entry_index = idx;
    if ($urandom_range(3) == 0) w.enter_code = '0;
    if ($urandom_range(3) == 0) w.update_code = '0;
    if ($urandom_range(3) == 0) w.exit_code = '0;
    w.flag = ($urandom_range(4) == 0);
    return w;
  endfunction

  function automatic tdfsm_pkg::in_item_t trans_load(logic [4:0] idx);
    tdfsm_pkg::in_item_t w;
    w = tdfsm_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    w.mode = tdfsm_pkg::MODE_LOAD_TRANS;
    w.entry_index = idx;
    w.from_state = pick_state();
    w.to_state = pick_state();
    w.trigger_kind = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    case (w.trigger_kind)
      tdfsm_pkg::TRIG_EVENT:
        if ($urandom_range(9) != 0) w.trigger_value = $urandom_range(0, 7);
      tdfsm_pkg::TRIG_COND:
        if ($urandom_range(9) != 0) w.trigger_value = $urandom_range(0, 19);
      tdfsm_pkg::TRIG_TIMEOUT:
        if ($urandom_range(9) != 0) w.trigger_value = $urandom_range(0, 300);
      default: ;
    endcase
    return w;
  endfunction

  function automatic tdfsm_pkg::in_item_t plain_word(logic [2:0] mode);
    tdfsm_pkg::in_item_t w;
    w = tdfsm_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    w.mode = mode;
    return w;
  endfunction

  // well-formed traffic with random content, plus some noise
  function automatic tdfsm_pkg::in_item_t pick_word();
    tdfsm_pkg::in_item_t w;
    int       r;
    r = $urandom_range(99);
    if (r < 45) begin
      w = plain_word(tdfsm_pkg::MODE_TICK);
      case ($urandom_range(9))
        0:       w.elapsed_ticks = '0;
        1:       w.elapsed_ticks = '1;
        2:       ;
        default: w.elapsed_ticks = $urandom_range(1, 60);
      endcase
    end else if (r < 65) begin
      w = plain_word(tdfsm_pkg::MODE_EVENT);
      if ($urandom_range(5) != 0) w.signal_id = $urandom_range(0, 7);
    end else if (r < 75) begin
      w = plain_word(tdfsm_pkg::MODE_SET_COND);
      if ($urandom_range(5) != 0) w.signal_id = $urandom_range(0, 19);
    end else if (r < 82) begin
      w = plain_word(tdfsm_pkg::MODE_START);
    end else if (r < 86) begin
      w = state_load(5'($urandom));
    end else if (r < 90) begin
      w = trans_load(5'($urandom));
    end else begin
      w = tdfsm_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
      if (w.mode == tdfsm_pkg::MODE_LOAD_STATE || w.mode == tdfsm_pkg::MODE_LOAD_TRANS)
        w = plain_word(3'd6);
    end
    return w;
  endfunction

  task automatic run_phase(input logic [3:0] init_v, input logic [4:0] sc,
                           input logic [5:0] tc, input int n_words);
    settle();
    write_regs(init_v, sc, tc, $urandom_range(1));
    send_word(plain_word(tdfsm_pkg::MODE_START));
    repeat (n_words) send_word(pick_word());
  endtask

  initial begin
    tdfsm_pkg::in_item_t w;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // tables empty and engine unconfigured: error paths and ignored words
    send_word(plain_word(3'd6));
    send_word(plain_word(3'd7));
    send_word(plain_word(tdfsm_pkg::MODE_START));
    send_word(plain_word(tdfsm_pkg::MODE_TICK));
    send_word(plain_word(tdfsm_pkg::MODE_EVENT));
    w = plain_word(tdfsm_pkg::MODE_SET_COND); w.signal_id = 8'hFF; w.flag = 1'b1;
    send_word(w);
    w = state_load(5'd16); send_word(w);
    w = state_load(5'd31); w.enter_code = '1; w.update_code = '1; w.exit_code = '1;
    send_word(w);

    // fill both tables so that no unwritten entry is ever read
    for (int i = 0; i < 16; i++) send_word(state_load(5'(i)));
    for (int i = 0; i < 32; i++) send_word(trans_load(5'(i)));

    // directed transitions from a known set-up
    settle();
    write_regs(4'd0, 5'd16, 6'd32, 1'b0);
    w = state_load(5'd0); w.enter_code = 8'hFF; w.update_code = 8'h01;
    w.exit_code = 8'h80; w.flag = 1'b0; send_word(w);
    w = state_load(5'd1); w.enter_code = 8'h11; w.update_code = '0;
    w.exit_code = '0; w.flag = 1'b1; send_word(w);
    w = trans_load(5'd0); w.from_state = 4'd0; w.to_state = 4'd1;
    w.trigger_kind = tdfsm_pkg::TRIG_EVENT; w.trigger_value = 32'd255; send_word(w);
    w = trans_load(5'd1); w.from_state = 4'd1; w.to_state = 4'd0;
    w.trigger_kind = tdfsm_pkg::TRIG_TIMEOUT; w.trigger_value = 32'd0; send_word(w);
    w = trans_load(5'd2); w.from_state = 4'd1; w.to_state = 4'd0;
    w.trigger_kind = tdfsm_pkg::TRIG_COND; w.trigger_value = 32'd15; send_word(w);
    w = trans_load(5'd3); w.from_state = 4'd0; w.to_state = 4'd15;
    w.trigger_kind = tdfsm_pkg::TRIG_TIMEOUT; w.trigger_value = 32'hFFFF_FFFF; send_word(w);
    send_word(plain_word(tdfsm_pkg::MODE_START));
    w = plain_word(tdfsm_pkg::MODE_EVENT); w.signal_id = 8'd255; send_word(w);
    w = plain_word(tdfsm_pkg::MODE_TICK); w.elapsed_ticks = '1; send_word(w);
    w = plain_word(tdfsm_pkg::MODE_SET_COND); w.signal_id = 8'd15; w.flag = 1'b1;
    send_word(w);
    w = plain_word(tdfsm_pkg::MODE_TICK); w.elapsed_ticks = '0; send_word(w);
    w = plain_word(tdfsm_pkg::MODE_SET_COND); w.signal_id = 8'd15; w.flag = 1'b0;
    send_word(w);

    // register settings, extremes first
    run_phase(4'd15, 5'd31, 6'd63, 40);
    run_phase(4'd0, 5'd0, 6'd0, 12);
    run_phase(4'd5, 5'd1, 6'd0, 20);
    run_phase(4'd2, 5'd16, 6'd32, 45);
    calm = 1'b1;
    run_phase(4'd1, 5'd6, 6'd20, 45);
    calm = 1'b0;
    for (int p = 0; p < 5; p++)
      run_phase(4'($urandom_range(0, 5)), 5'($urandom_range(1, 31)),
                6'($urandom_range(0, 63)), 40);

    settle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
